// ===== design/image_header_dimension_parser_assert.svh =====
// ----------------------------------------------------------------------------
// image_header_dimension_parser_assert.svh
// Assertion macros for the parser RTL.
// ----------------------------------------------------------------------------
`ifndef IMAGE_HEADER_DIMENSION_PARSER_ASSERT_SVH
`define IMAGE_HEADER_DIMENSION_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IHDP_ASSERT_IMPL(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define IHDP_ASSERT_NEXT(label, clk, cond, expr) \
   label: assert property (@(posedge clk) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

// ===== design/ihdp_pkg.sv =====
// ----------------------------------------------------------------------------
// ihdp_pkg
// Types and constants for the image header dimension parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ihdp_pkg;

   localparam int HDR_BYTES = 30;
   localparam int CNT_W     = 5;

   typedef logic [HDR_BYTES-1:0][7:0] hdr_bytes_type;

   typedef enum logic [2:0] {
      FMT_NONE          = 3'd0,
      FMT_PNG           = 3'd1,
      FMT_WEBP_EXT      = 3'd2,
      FMT_WEBP_LOSSLESS = 3'd3,
      FMT_WEBP_LOSSY    = 3'd4
   } format_type;

   localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;
   localparam logic [31:0] TAG_IHDR  = 32'h49484452;
   localparam logic [31:0] TAG_RIFF  = 32'h52494646;
   localparam logic [31:0] TAG_WEBP  = 32'h57454250;
   localparam logic [31:0] TAG_VP8X  = 32'h56503858;
   localparam logic [31:0] TAG_VP8L  = 32'h5650384C;
   localparam logic [31:0] TAG_VP8   = 32'h56503820;
   localparam logic [7:0]  VP8L_SIG  = 8'h2F;
   localparam logic [23:0] VP8_START = 24'h9D012A;
   localparam logic [13:0] DIM_MASK  = 14'h3FFF;

   // Capture stage to judge stage: frozen header and its byte count.
   typedef struct packed {
      logic                 pend;
      logic [CNT_W-1:0]     n;
      hdr_bytes_type        hdr;
   } capture_type;

   typedef struct packed {
      logic        found;
      format_type  format;
      logic [31:0] width;
      logic [31:0] height;
   } verdict_type;

endpackage

// ===== design/ihdp_capture.sv =====
// ----------------------------------------------------------------------------
// ihdp_capture
// Stores the first bytes of each file, counts them and drops the tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ihdp_capture (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_file,
   input  logic                  advance,
   output ihdp_pkg::capture_type cap
);

   ihdp_pkg::hdr_bytes_type       store_ff;
   logic [ihdp_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [ihdp_pkg::CNT_W-1:0]    n_ff, n_in;
   logic                          drain_ff, drain_in;
   logic                          pend_ff, pend_in;
   logic                          accept;
   logic                          store_en;
   logic                          last_byte;
   logic [ihdp_pkg::CNT_W-1:0]    count_inc;

   // Store is frozen while a header waits for the judge stage.
   assign req_ready = !pend_ff || advance;
   assign accept    = req_valid && req_ready;
   assign store_en  = accept && !drain_ff;
   assign count_inc = count_ff + ihdp_pkg::CNT_W'(1);
   assign last_byte = (count_inc == ihdp_pkg::CNT_W'(ihdp_pkg::HDR_BYTES)) || req_end_of_file;

   always_comb begin
      count_in = count_ff;
      drain_in = drain_ff;
      n_in     = n_ff;
      pend_in  = pend_ff && !advance;
      if (accept) begin
         if (drain_ff) begin
            if (req_end_of_file) begin
               drain_in = 1'b0;
               count_in = '0;
            end
         end else if (last_byte) begin
            pend_in  = 1'b1;
            n_in     = count_inc;
            count_in = '0;
            drain_in = !req_end_of_file;
         end else begin
            count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drain_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         drain_ff <= drain_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      if (store_en) begin
         store_ff[count_ff] <= req_data_byte;
      end
   end

   assign cap.pend = pend_ff;
   assign cap.n    = n_ff;
   assign cap.hdr  = store_ff;

endmodule

// ===== design/ihdp_judge.sv =====
// ----------------------------------------------------------------------------
// ihdp_judge
// Decodes a captured header as PNG, then as WebP (VP8X, VP8L, VP8).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ihdp_judge (
   input  ihdp_pkg::capture_type cap,
   output ihdp_pkg::verdict_type verdict
);

   ihdp_pkg::hdr_bytes_type h;
   logic [63:0] magic;
   logic [31:0] tag0, tag8, tag12;
   logic [31:0] png_w, png_h;
   logic [31:0] vp8l_bits;
   logic [13:0] lossy_w, lossy_h;
   logic        png_ok, riff_ok;

   assign h     = cap.hdr;
   assign magic = {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
   assign tag0  = {h[0], h[1], h[2], h[3]};
   assign tag8  = {h[8], h[9], h[10], h[11]};
   assign tag12 = {h[12], h[13], h[14], h[15]};
   assign png_w = {h[16], h[17], h[18], h[19]};
   assign png_h = {h[20], h[21], h[22], h[23]};
   assign vp8l_bits = {h[24], h[23], h[22], h[21]};
   assign lossy_w   = {h[27][5:0], h[26]} & ihdp_pkg::DIM_MASK;
   assign lossy_h   = {h[29][5:0], h[28]} & ihdp_pkg::DIM_MASK;

   assign png_ok  = (cap.n >= ihdp_pkg::CNT_W'(24)) && (magic == ihdp_pkg::PNG_MAGIC)
                    && (tag12 == ihdp_pkg::TAG_IHDR) && (png_w != '0) && (png_h != '0);
   assign riff_ok = (cap.n >= ihdp_pkg::CNT_W'(16)) && (tag0 == ihdp_pkg::TAG_RIFF)
                    && (tag8 == ihdp_pkg::TAG_WEBP);

   always_comb begin
      verdict.found  = 1'b0;
      verdict.format = ihdp_pkg::FMT_NONE;
      verdict.width  = '0;
      verdict.height = '0;
      if (png_ok) begin
         verdict.format = ihdp_pkg::FMT_PNG;
         verdict.width  = png_w;
         verdict.height = png_h;
      end else if (riff_ok) begin
         if (tag12 == ihdp_pkg::TAG_VP8X) begin
            if (cap.n >= ihdp_pkg::CNT_W'(30)) begin
               verdict.format = ihdp_pkg::FMT_WEBP_EXT;
               verdict.width  = {8'd0, h[26], h[25], h[24]} + 32'd1;
               verdict.height = {8'd0, h[29], h[28], h[27]} + 32'd1;
            end
         end else if (tag12 == ihdp_pkg::TAG_VP8L) begin
            if ((cap.n >= ihdp_pkg::CNT_W'(25)) && (h[20] == ihdp_pkg::VP8L_SIG)) begin
               verdict.format = ihdp_pkg::FMT_WEBP_LOSSLESS;
               verdict.width  = {18'd0, vp8l_bits[13:0]} + 32'd1;
               verdict.height = {18'd0, vp8l_bits[27:14]} + 32'd1;
            end
         end else if (tag12 == ihdp_pkg::TAG_VP8) begin
            if ((cap.n >= ihdp_pkg::CNT_W'(30)) && ({h[23], h[24], h[25]} == ihdp_pkg::VP8_START)
                && (lossy_w != '0) && (lossy_h != '0)) begin
               verdict.format = ihdp_pkg::FMT_WEBP_LOSSY;
               verdict.width  = {18'd0, lossy_w};
               verdict.height = {18'd0, lossy_h};
            end
         end
      end
      verdict.found = (verdict.format != ihdp_pkg::FMT_NONE);
   end

endmodule

// ===== design/image_header_dimension_parser.sv =====
// ----------------------------------------------------------------------------
// image_header_dimension_parser
// Reads PNG / WebP image dimensions from the leading bytes of a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one file byte per transfer, req_end_of_file on the last byte.
//   rsp_*  : one result per file: found, format, image_width, image_height.
//   A result is produced when the 30th byte of a file arrives or on the
//   end-of-file byte, whichever is first. Bytes after the 30th are dropped
//   until end of file, which re-arms the parser for the next file.
//   Result path: the deciding byte sets the capture register, then the result
//   register loads the verdict and raises rsp_valid once it is free.
//   Throughput: one byte per cycle unless stalled; the store is written at
//   one address per cycle; decoding is one pass into the result register.
//   Stall: while rsp_ready is low the result register holds and one more
//   header may be captured; further bytes are then held off with
//   req_ready low until the result register drains.
//   Reset: synchronous, clears counters and valid flags; no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "image_header_dimension_parser_assert.svh"

module image_header_dimension_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [2:0]  rsp_format,
   output logic [31:0] rsp_image_width,
   output logic [31:0] rsp_image_height
);

   ihdp_pkg::capture_type cap;
   ihdp_pkg::verdict_type verdict;
   ihdp_pkg::verdict_type rsp_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  advance;

   // Move a captured header into the result register when it is free.
   assign advance      = cap.pend && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   ihdp_capture u_capture (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_file (req_end_of_file),
      .advance         (advance),
      .cap             (cap)
   );

   ihdp_judge u_judge (
      .cap     (cap),
      .verdict (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= verdict;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_ff.found;
   assign rsp_format       = rsp_ff.format;
   assign rsp_image_width  = rsp_ff.width;
   assign rsp_image_height = rsp_ff.height;

   `IHDP_ASSERT_IMPL(a_hold_off, clock, reset, cap.pend && rsp_valid && !rsp_ready, !req_ready)
   `IHDP_ASSERT_IMPL(a_found_fmt, clock, reset, rsp_valid,
      rsp_found == (rsp_format != ihdp_pkg::FMT_NONE))
   `IHDP_ASSERT_IMPL(a_zero_dims, clock, reset, rsp_valid && !rsp_found,
      (rsp_image_width == '0) && (rsp_image_height == '0))
   `IHDP_ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_valid && !cap.pend)

endmodule

// ===== test/image_header_dimension_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_header_dimension_checker
// Watches the byte and result channels of the header parser, rebuilds each
// file's leading bytes from the byte transfers, decodes the expected
// format and dimensions, and compares every result transfer in order.
// ----------------------------------------------------------------------------
module image_header_dimension_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_found,
   input  logic [2:0]  rsp_format,
   input  logic [31:0] rsp_image_width,
   input  logic [31:0] rsp_image_height,
   output int          mismatch_count,
   output int          results_pending
);

   localparam int REPORT_LIMIT = 10;

   logic [7:0]            hdr_seen [0:ihdp_pkg::HDR_BYTES-1];
   int                    bytes_held;
   logic                  skipping_tail;
   ihdp_pkg::verdict_type pending_verdicts [$];
   int                    mismatches;

   assign mismatch_count = mismatches;

   function automatic logic [31:0] word_at(input int i);
      return {hdr_seen[i], hdr_seen[i+1], hdr_seen[i+2], hdr_seen[i+3]};
   endfunction

   // Offsets are only read once the byte count shows they belong to this file.
   function automatic ihdp_pkg::verdict_type decode_header(input int n);
      ihdp_pkg::verdict_type v;
      logic [31:0] lossless_bits;
      logic [13:0] lossy_w;
      logic [13:0] lossy_h;
      v = '0;
      if (n >= 24 && {word_at(0), word_at(4)} == ihdp_pkg::PNG_MAGIC
          && word_at(12) == ihdp_pkg::TAG_IHDR
          && word_at(16) != 32'd0 && word_at(20) != 32'd0) begin
         v.found  = 1'b1;
         v.format = ihdp_pkg::FMT_PNG;
         v.width  = word_at(16);
         v.height = word_at(20);
         return v;
      end
      if (n < 16 || word_at(0) != ihdp_pkg::TAG_RIFF || word_at(8) != ihdp_pkg::TAG_WEBP)
         return v;
      if (word_at(12) == ihdp_pkg::TAG_VP8X) begin
         if (n >= 30) begin
            v.found  = 1'b1;
            v.format = ihdp_pkg::FMT_WEBP_EXT;
            v.width  = {8'd0, hdr_seen[26], hdr_seen[25], hdr_seen[24]} + 32'd1;
            v.height = {8'd0, hdr_seen[29], hdr_seen[28], hdr_seen[27]} + 32'd1;
         end
      end else if (word_at(12) == ihdp_pkg::TAG_VP8L) begin
         if (n >= 25 && hdr_seen[20] == ihdp_pkg::VP8L_SIG) begin
            lossless_bits = {hdr_seen[24], hdr_seen[23], hdr_seen[22], hdr_seen[21]};
            v.found  = 1'b1;
            v.format = ihdp_pkg::FMT_WEBP_LOSSLESS;
            v.width  = {18'd0, lossless_bits[13:0]} + 32'd1;
            v.height = {18'd0, lossless_bits[27:14]} + 32'd1;
         end
      end else if (word_at(12) == ihdp_pkg::TAG_VP8) begin
         if (n >= 30) begin
            lossy_w = {hdr_seen[27][5:0], hdr_seen[26]};
            lossy_h = {hdr_seen[29][5:0], hdr_seen[28]};
            if ({hdr_seen[23], hdr_seen[24], hdr_seen[25]} == ihdp_pkg::VP8_START
                && lossy_w != 14'd0 && lossy_h != 14'd0) begin
               v.found  = 1'b1;
               v.format = ihdp_pkg::FMT_WEBP_LOSSY;
               v.width  = {18'd0, lossy_w};
               v.height = {18'd0, lossy_h};
            end
         end
      end
      return v;
   endfunction

   task automatic take_file_byte(input logic [7:0] value, input logic last);
      if (skipping_tail) begin
         if (last) begin
            skipping_tail = 1'b0;
            bytes_held    = 0;
         end
         return;
      end
      if (bytes_held < ihdp_pkg::HDR_BYTES) begin
         hdr_seen[bytes_held] = value;
         bytes_held++;
      end
      if (bytes_held < ihdp_pkg::HDR_BYTES && !last)
         return;
      pending_verdicts.push_back(decode_header(bytes_held));
      bytes_held    = 0;
      skipping_tail = !last;
   endtask

   task automatic check_result();
      ihdp_pkg::verdict_type want;
      if (pending_verdicts.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: found=%0b format=%0d width=%0d height=%0d",
                     rsp_found, rsp_format, rsp_image_width, rsp_image_height);
         return;
      end
      want = pending_verdicts.pop_front();
      if (rsp_found !== want.found || rsp_format !== want.format
          || rsp_image_width !== want.width || rsp_image_height !== want.height) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("mismatch: expected found=%0b format=%0d width=%0d height=%0d,",
                     want.found, want.format, want.width, want.height,
                     " got found=%0b format=%0d width=%0d height=%0d",
                     rsp_found, rsp_format, rsp_image_width, rsp_image_height);
      end
   endtask

   initial begin
      mismatches    = 0;
      bytes_held    = 0;
      skipping_tail = 1'b0;
   end

   // Results are checked before the byte of the same edge is taken, so a
   // result can never be matched against a prediction made in that cycle.
   always @(posedge clock) begin
      if (reset) begin
         bytes_held    = 0;
         skipping_tail = 1'b0;
         pending_verdicts.delete();
         results_pending = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_result();
         if (req_valid && req_ready)
            take_file_byte(req_data_byte, req_end_of_file);
         results_pending = pending_verdicts.size();
      end
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams PNG and WebP headers, truncated and corrupted files and plain noise
// through the header parser with random idle and stall cycles on both sides.
// ----------------------------------------------------------------------------
module testbench;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 6;
   localparam int TARGET_BYTES   = 1300;
   localparam int SETTLE_CYCLES  = 10;
   localparam int CYCLE_LIMIT    = 600000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_end_of_file;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_found;
   logic [2:0]  rsp_format;
   logic [31:0] rsp_image_width;
   logic [31:0] rsp_image_height;

   int          mismatch_count;
   int          results_pending;
   int          cycle_count = 0;
   int          bytes_sent = 0;
   logic [7:0]  file_img [0:ihdp_pkg::HDR_BYTES-1];
   bit          tx_steady = 1'b0;
   bit          rx_steady = 1'b0;
   int          hold_left = 0;
   int          rx_roll;

   image_header_dimension_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_file  (req_end_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_format       (rsp_format),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height)
   );

   image_header_dimension_checker header_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_file  (req_end_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_format       (rsp_format),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .mismatch_count   (mismatch_count),
      .results_pending  (results_pending)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side: short and long stalls, with quiet stretches in between.
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0)
         rx_steady = !rx_steady;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rx_roll = $urandom_range(0, 99);
         if (!rx_steady) begin
            if (rx_roll < 20)
               hold_left = $urandom_range(1, 3);
            else if (rx_roll < 24)
               hold_left = $urandom_range(10, 40);
         end
      end
   end

   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (tx_steady || roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int tail_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return $urandom_range(0, 3);
      if (roll < 90)
         return $urandom_range(4, 12);
      return $urandom_range(13, 50);
   endfunction

   function automatic logic [31:0] pick_dim();
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'd1;
         default: return $urandom;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic stream_byte(input logic [7:0] value, input logic last);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= value;
      req_end_of_file <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_image_file(input int flen);
      logic [7:0] tail_byte;
      tx_steady = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < flen; i++) begin
         tail_byte = 8'($urandom);
         stream_byte((i < ihdp_pkg::HDR_BYTES) ? file_img[i] : tail_byte, i == flen - 1);
      end
      bytes_sent += flen;
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_pending != 0)
         @(negedge clock);
   endtask

   task automatic put_bytes_be(input int pos, input logic [63:0] value, input int count);
      for (int k = 0; k < count; k++)
         file_img[pos+k] = value[8*(count-1-k) +: 8];
   endtask

   task automatic put_bytes_le(input int pos, input logic [31:0] value, input int count);
      for (int k = 0; k < count; k++)
         file_img[pos+k] = value[8*k +: 8];
   endtask

   task automatic fill_noise();
      for (int i = 0; i < ihdp_pkg::HDR_BYTES; i++)
         file_img[i] = 8'($urandom);
   endtask

   task automatic form_riff_webp(input logic [31:0] chunk_tag);
      fill_noise();
      put_bytes_be(0, 64'(ihdp_pkg::TAG_RIFF), 4);
      put_bytes_be(8, 64'(ihdp_pkg::TAG_WEBP), 4);
      put_bytes_be(12, 64'(chunk_tag), 4);
   endtask

   task automatic form_png(input logic [31:0] w, input logic [31:0] h);
      fill_noise();
      put_bytes_be(0, ihdp_pkg::PNG_MAGIC, 8);
      put_bytes_be(8, 64'd13, 4);
      put_bytes_be(12, 64'(ihdp_pkg::TAG_IHDR), 4);
      put_bytes_be(16, 64'(w), 4);
      put_bytes_be(20, 64'(h), 4);
   endtask

   task automatic form_vp8x(input logic [31:0] w_minus1, input logic [31:0] h_minus1);
      form_riff_webp(ihdp_pkg::TAG_VP8X);
      put_bytes_le(24, w_minus1, 3);
      put_bytes_le(27, h_minus1, 3);
   endtask

   task automatic form_vp8l(input logic [7:0] sig, input logic [31:0] bits);
      form_riff_webp(ihdp_pkg::TAG_VP8L);
      file_img[20] = sig;
      put_bytes_le(21, bits, 4);
   endtask

   task automatic form_vp8(input logic [23:0] start, input logic [31:0] w,
                           input logic [31:0] h);
      form_riff_webp(ihdp_pkg::TAG_VP8);
      put_bytes_be(23, 64'(start), 3);
      put_bytes_le(26, w, 2);
      put_bytes_le(28, h, 2);
   endtask

   task automatic send_random_file();
      int         kind;
      int         shape;
      int         min_len;
      int         flen;
      int         idx;
      logic [7:0] flip;
      kind  = $urandom_range(0, 4);
      shape = $urandom_range(0, 99);
      case (kind)
         0: begin
            form_png(pick_dim(), pick_dim());
            min_len = 24;
         end
         1: begin
            form_vp8x(pick_dim(), pick_dim());
            min_len = 30;
         end
         2: begin
            form_vp8l(ihdp_pkg::VP8L_SIG, pick_dim());
            min_len = 25;
         end
         3: begin
            form_vp8(ihdp_pkg::VP8_START, pick_dim(), pick_dim());
            min_len = 30;
         end
         default: begin
            // noise, sometimes behind a plausible prefix
            case ($urandom_range(0, 3))
               0:       form_png($urandom, $urandom);
               1:       form_riff_webp($urandom);
               default: fill_noise();
            endcase
            min_len = $urandom_range(1, 30);
         end
      endcase
      if (shape >= 70 && shape < 85) begin
         idx  = $urandom_range(0, ihdp_pkg::HDR_BYTES - 1);
         flip = 8'($urandom_range(1, 255));
         file_img[idx] = file_img[idx] ^ flip;
      end
      if (shape >= 85 && min_len > 1)
         flen = $urandom_range(1, min_len - 1);
      else
         flen = min_len + tail_len();
      send_image_file(flen);
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data_byte   = 8'd0;
      req_end_of_file = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes of each format and the short-file cases
      form_png(32'hFFFF_FFFF, 32'd1);
      send_image_file(24);
      form_png(32'd1, 32'hFFFF_FFFF);
      send_image_file(45);
      form_png(32'd0, 32'd100);
      send_image_file(30);
      form_png(32'd640, 32'd480);
      send_image_file(23);
      form_vp8x(32'hFF_FFFF, 32'hFF_FFFF);
      send_image_file(30);
      form_vp8x(32'd0, 32'd0);
      send_image_file(31);
      form_vp8x(32'd99, 32'd99);
      send_image_file(29);
      form_vp8l(ihdp_pkg::VP8L_SIG, 32'hFFFF_FFFF);
      send_image_file(25);
      form_vp8l(ihdp_pkg::VP8L_SIG, 32'd0);
      send_image_file(24);
      form_vp8l(ihdp_pkg::VP8L_SIG ^ 8'h01, 32'h1234_5678);
      send_image_file(30);
      form_vp8(ihdp_pkg::VP8_START, 32'hFFFF, 32'hFFFF);
      send_image_file(33);
      form_vp8(ihdp_pkg::VP8_START, 32'hC000, 32'd1);
      send_image_file(30);
      form_vp8(ihdp_pkg::VP8_START ^ 24'h000100, 32'd100, 32'd100);
      send_image_file(30);
      form_vp8(ihdp_pkg::VP8_START, 32'd1, 32'd1);
      send_image_file(29);
      form_riff_webp(ihdp_pkg::TAG_VP8X ^ 32'd1);
      send_image_file(30);
      form_riff_webp(ihdp_pkg::TAG_VP8L);
      send_image_file(16);
      for (int i = 0; i < ihdp_pkg::HDR_BYTES; i++)
         file_img[i] = 8'hFF;
      send_image_file(30);
      file_img[0] = 8'h00;
      send_image_file(1);
      fill_noise();
      send_image_file(60);

      wait_results_drained();

      while (bytes_sent < TARGET_BYTES) begin
         send_random_file();
         if ($urandom_range(0, 19) == 0)
            wait_results_drained();
      end

      req_valid <= 1'b0;
      while (results_pending != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && results_pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
